// ===== hw/rtl/lzss_window_decompressor_core_macros.svh =====
// Assertion macros for the LZSS window decompressor checker.
// No dependencies; included by the checker file only.
`ifndef LZSS_WINDOW_DECOMPRESSOR_CORE_MACROS_SVH
`define LZSS_WINDOW_DECOMPRESSOR_CORE_MACROS_SVH

// Checked only outside reset.
`define LZWD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define LZWD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== hw/rtl/lzwd_pkg.sv =====
// Shared types and constants for the LZSS window decompressor.
// No dependencies; used by every RTL module of the block but the checker.
`default_nettype none

package lzwd_pkg;

    localparam int WIN_AW    = 12;
    localparam int WIN_DEPTH = 1 << WIN_AW;

    localparam logic [WIN_AW-1:0] WIN_LAST  = WIN_AW'(WIN_DEPTH - 1);
    localparam logic [WIN_AW-1:0] WP_RESET  = WIN_AW'(1);
    localparam logic [WIN_AW-1:0] POS_END   = '0;
    localparam logic [4:0]        LEN_BIAS  = 5'd2;

    typedef enum logic [1:0] {
        PH_FLAG = 2'd0,
        PH_LIT  = 2'd1,
        PH_HEAD = 2'd2,
        PH_TAIL = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        ENG_CLEAR = 2'd0,
        ENG_IDLE  = 2'd1,
        ENG_COPY  = 2'd2
    } t_eng_state;

    typedef struct packed {
        logic              we;
        logic [WIN_AW-1:0] waddr;
        logic [7:0]        wdata;
        logic              re;
        logic [WIN_AW-1:0] raddr;
    } t_ram_req;

endpackage

`default_nettype wire

// ===== hw/rtl/lzwd_window_ram.sv =====
// 4096 x 8 history window: one write and one registered read per cycle.
// Depends on lzwd_pkg. A read of the entry being written returns the new byte.
`default_nettype none

module lzwd_window_ram (
    input  logic                i_clk,
    input  lzwd_pkg::t_ram_req  i_req,
    output logic [7:0]          o_rdata
);

    logic [7:0] r_mem [lzwd_pkg::WIN_DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    // write-first: covers a copy whose source is the byte just written
    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            if (i_req.we && (i_req.waddr == i_req.raddr)) begin
                r_rdata <= i_req.wdata;
            end else begin
                r_rdata <= r_mem[i_req.raddr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hw/rtl/lzwd_ctrl.sv =====
// Token parser, match copy sequencer, window clear sweep and output register.
// Depends on lzwd_pkg; drives the window RAM through a t_ram_req struct.
`default_nettype none

module lzwd_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [7:0]          i_in_byte,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [7:0]          o_out_byte,
    output logic                o_last,
    output logic                o_stream_end,
    output lzwd_pkg::t_ram_req  o_ram_req,
    input  logic [7:0]          i_ram_rdata
);

    lzwd_pkg::t_eng_state          r_state, n_state;
    lzwd_pkg::t_phase              r_phase, n_phase;
    logic [7:0]                    r_flags, n_flags;
    logic [2:0]                    r_bit, n_bit;
    logic [7:0]                    r_head, n_head;
    logic [lzwd_pkg::WIN_AW-1:0]   r_wp, n_wp;
    logic [lzwd_pkg::WIN_AW-1:0]   r_clr, n_clr;
    logic [lzwd_pkg::WIN_AW-1:0]   r_src, n_src;
    logic [4:0]                    r_left, n_left;
    logic                          r_ovalid, n_ovalid;
    logic [7:0]                    r_obyte, n_obyte;
    logic                          r_olast, n_olast;
    logic                          r_oend, n_oend;

    logic                          out_free;
    logic                          in_beat;
    logic [2:0]                    td_bit;
    lzwd_pkg::t_phase              td_phase;
    logic [lzwd_pkg::WIN_AW-1:0]   tail_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= lzwd_pkg::ENG_CLEAR;
            r_phase  <= lzwd_pkg::PH_FLAG;
            r_flags  <= '0;
            r_bit    <= '0;
            r_head   <= '0;
            r_wp     <= lzwd_pkg::WP_RESET;
            r_clr    <= '0;
            r_left   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_flags  <= n_flags;
            r_bit    <= n_bit;
            r_head   <= n_head;
            r_wp     <= n_wp;
            r_clr    <= n_clr;
            r_left   <= n_left;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_src   <= n_src;
        r_obyte <= n_obyte;
        r_olast <= n_olast;
        r_oend  <= n_oend;
    end

    // phase after a literal or a completed match
    always_comb begin
        td_bit = r_bit + 3'd1;
        if (r_bit == 3'd7) begin
            td_phase = lzwd_pkg::PH_FLAG;
        end else if (r_flags[td_bit]) begin
            td_phase = lzwd_pkg::PH_LIT;
        end else begin
            td_phase = lzwd_pkg::PH_HEAD;
        end
    end

    assign out_free = !r_ovalid || i_ready;
    assign tail_pos = {r_head[3:0], i_in_byte};

    always_comb begin
        n_state  = r_state;
        n_phase  = r_phase;
        n_flags  = r_flags;
        n_bit    = r_bit;
        n_head   = r_head;
        n_wp     = r_wp;
        n_clr    = r_clr;
        n_src    = r_src;
        n_left   = r_left;
        n_ovalid = r_ovalid && !i_ready;
        n_obyte  = r_obyte;
        n_olast  = r_olast;
        n_oend   = r_oend;
        o_ram_req = '0;
        o_ready  = 1'b0;
        in_beat  = 1'b0;

        case (r_state)
            lzwd_pkg::ENG_CLEAR: begin
                o_ram_req.we    = 1'b1;
                o_ram_req.waddr = r_clr;
                o_ram_req.wdata = '0;
                n_clr = r_clr + 1'b1;
                if (r_clr == lzwd_pkg::WIN_LAST) begin
                    n_state = lzwd_pkg::ENG_IDLE;
                end
            end
            lzwd_pkg::ENG_IDLE: begin
                o_ready = out_free;
                in_beat = i_valid && out_free;
                if (in_beat) begin
                    case (r_phase)
                        lzwd_pkg::PH_FLAG: begin
                            n_flags = i_in_byte;
                            n_bit   = '0;
                            n_phase = i_in_byte[0] ? lzwd_pkg::PH_LIT : lzwd_pkg::PH_HEAD;
                        end
                        lzwd_pkg::PH_LIT: begin
                            o_ram_req.we    = 1'b1;
                            o_ram_req.waddr = r_wp;
                            o_ram_req.wdata = i_in_byte;
                            n_wp     = r_wp + 1'b1;
                            n_ovalid = 1'b1;
                            n_obyte  = i_in_byte;
                            n_olast  = 1'b1;
                            n_oend   = 1'b0;
                            n_bit    = td_bit;
                            n_phase  = td_phase;
                        end
                        lzwd_pkg::PH_HEAD: begin
                            n_head  = i_in_byte;
                            n_phase = lzwd_pkg::PH_TAIL;
                        end
                        lzwd_pkg::PH_TAIL: begin
                            if (tail_pos == lzwd_pkg::POS_END) begin
                                n_ovalid = 1'b1;
                                n_obyte  = '0;
                                n_olast  = 1'b1;
                                n_oend   = 1'b1;
                                n_phase  = lzwd_pkg::PH_FLAG;
                                n_flags  = '0;
                                n_bit    = '0;
                                n_head   = '0;
                                n_wp     = lzwd_pkg::WP_RESET;
                            end else begin
                                o_ram_req.re    = 1'b1;
                                o_ram_req.raddr = tail_pos;
                                n_src   = tail_pos + 1'b1;
                                n_left  = {1'b0, r_head[7:4]} + lzwd_pkg::LEN_BIAS;
                                n_state = lzwd_pkg::ENG_COPY;
                            end
                        end
                        default: begin
                            n_phase = lzwd_pkg::PH_FLAG;
                        end
                    endcase
                end
            end
            lzwd_pkg::ENG_COPY: begin
                // read data for this byte was fetched last issue and holds while stalled
                if (out_free) begin
                    o_ram_req.we    = 1'b1;
                    o_ram_req.waddr = r_wp;
                    o_ram_req.wdata = i_ram_rdata;
                    n_wp     = r_wp + 1'b1;
                    n_ovalid = 1'b1;
                    n_obyte  = i_ram_rdata;
                    n_olast  = (r_left == 5'd1);
                    n_oend   = 1'b0;
                    n_left   = r_left - 5'd1;
                    if (r_left != 5'd1) begin
                        o_ram_req.re    = 1'b1;
                        o_ram_req.raddr = r_src;
                        n_src = r_src + 1'b1;
                    end else begin
                        n_state = lzwd_pkg::ENG_IDLE;
                        n_bit   = td_bit;
                        n_phase = td_phase;
                    end
                end
            end
            default: begin
                n_state = lzwd_pkg::ENG_IDLE;
            end
        endcase
    end

    assign o_valid      = r_ovalid;
    assign o_out_byte   = r_obyte;
    assign o_last       = r_olast;
    assign o_stream_end = r_oend;

endmodule

`default_nettype wire

// ===== hw/rtl/lzss_window_decompressor_core.sv =====
// LZSS decompressor with a 4096-byte history window.
// Input channel (i_valid/o_ready, i_in_byte): one compressed byte per beat.
// Output channel (o_valid/i_ready): o_out_byte, o_last, o_stream_end.
// Flag bytes and first match bytes give no output. A literal gives one result
// in the cycle after its beat. A match gives 2..17 results: the first passes
// through the window read register and the output register after the second
// match byte, then one per cycle while i_ready allows, set by the single window
// read and write port. A match item therefore holds the input until its copy ends.
// o_last marks the final result of each input byte; an end marker (position
// zero) gives one result with o_stream_end and o_out_byte zero, and restarts
// the parser with write position one, keeping the window contents.
// Reset (synchronous, i_rst_n low) starts a clearing sweep that zeroes the
// window one entry a cycle: o_ready stays low until all 4096 entries are cleared.
// While the receiver holds i_ready low the output register keeps its beat and
// the copy sequencer pauses; o_ready is low until the output register frees.
// Depends on lzwd_pkg, lzwd_ctrl and lzwd_window_ram.
`default_nettype none

module lzss_window_decompressor_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_in_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_last,
    output logic        o_stream_end
);

    lzwd_pkg::t_ram_req ram_req;
    logic [7:0]         ram_rdata;

    lzwd_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_in_byte    (i_in_byte),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_out_byte   (o_out_byte),
        .o_last       (o_last),
        .o_stream_end (o_stream_end),
        .o_ram_req    (ram_req),
        .i_ram_rdata  (ram_rdata)
    );

    lzwd_window_ram u_win (
        .i_clk   (i_clk),
        .i_req   (ram_req),
        .o_rdata (ram_rdata)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/lzwd_checker.sv =====
// Port-level checks for lzss_window_decompressor_core, attached by bind.
// Depends on lzss_window_decompressor_core_macros.svh.
`default_nettype none

`include "lzss_window_decompressor_core_macros.svh"

module lzwd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic       o_valid,
    input logic       i_ready,
    input logic [7:0] o_out_byte,
    input logic       o_last,
    input logic       o_stream_end
);

    // reset starts the clearing sweep: nothing taken, nothing shown
    `LZWD_ASSERT_ALWAYS(a_reset_quiet, !i_rst_n |=> !o_ready && !o_valid, "busy after reset")

    `LZWD_ASSERT(a_end_is_last, o_valid && o_stream_end |-> o_last && o_out_byte == '0, "end beat")

    // a match still in progress must block the input side
    `LZWD_ASSERT(a_copy_blocks_in, o_valid && !o_last |-> !o_ready, "input taken mid-match")

    `LZWD_ASSERT(a_out_hold, o_valid && !i_ready |=> o_valid && $stable(o_out_byte), "held beat")

endmodule

bind lzss_window_decompressor_core lzwd_checker u_lzwd_checker (.*);

`default_nettype wire

// ===== dv/tb_lzss_window_decompressor_core.sv =====
// Self-checking testbench for lzss_window_decompressor_core: directed table, then random
// flag/literal/match streams with random source gaps and sink stalls, scoreboarded beat by beat.
// Depends on lzwd_pkg and the lzss_window_decompressor_core RTL.
`default_nettype none

module tb_lzss_window_decompressor_core;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [lzwd_pkg::WIN_AW-1:0] t_win_addr;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       stream_end;
    } t_out_beat;

    typedef struct packed {
        logic [7:0] in_b;
        logic       typed;
        t_out_beat  beat;
    } t_dir_row;

    localparam t_out_beat NO_BEAT     = '0;
    localparam int        CYCLE_LIMIT = 500_000;
    localparam int        PHASE_ITEMS = 85;
    localparam int        SETTLE_CYC  = 40;
    localparam int        HOLD_CYC    = 400;
    localparam int        TX_IDLE [4] = '{0, 68, 0, 34};
    localparam int        RX_STALL[4] = '{0, 0, 68, 34};

    localparam int DIR_N = 24;
    localparam t_dir_row DIR_TAB [DIR_N] = '{
        '{8'hA7, 1'b0, NO_BEAT},                 // flag: L L L M M L M L
        '{8'h00, 1'b1, '{8'h00, 1'b1, 1'b0}},
        '{8'hFF, 1'b1, '{8'hFF, 1'b1, 1'b0}},
        '{8'h5A, 1'b1, '{8'h5A, 1'b1, 1'b0}},
        '{8'hF0, 1'b0, NO_BEAT},                 // 17-byte copy overlapping its own output
        '{8'h01, 1'b0, NO_BEAT},
        '{8'h0F, 1'b0, NO_BEAT},                 // 2-byte copy across the top of the window
        '{8'hFF, 1'b0, NO_BEAT},
        '{8'h81, 1'b1, '{8'h81, 1'b1, 1'b0}},
        '{8'h30, 1'b0, NO_BEAT},
        '{8'h02, 1'b0, NO_BEAT},
        '{8'h7E, 1'b1, '{8'h7E, 1'b1, 1'b0}},   // eighth token, next byte is a flag
        '{8'h00, 1'b0, NO_BEAT},                 // flag: all matches
        '{8'hA0, 1'b0, NO_BEAT},                 // end marker, length nibble ignored
        '{8'h00, 1'b1, '{8'h00, 1'b1, 1'b1}},
        '{8'hFF, 1'b0, NO_BEAT},                 // flag: all literals
        '{8'h01, 1'b1, '{8'h01, 1'b1, 1'b0}},
        '{8'h02, 1'b1, '{8'h02, 1'b1, 1'b0}},
        '{8'h04, 1'b1, '{8'h04, 1'b1, 1'b0}},
        '{8'h08, 1'b1, '{8'h08, 1'b1, 1'b0}},
        '{8'h10, 1'b1, '{8'h10, 1'b1, 1'b0}},
        '{8'h20, 1'b1, '{8'h20, 1'b1, 1'b0}},
        '{8'h40, 1'b1, '{8'h40, 1'b1, 1'b0}},
        '{8'h80, 1'b1, '{8'h80, 1'b1, 1'b0}}
    };

    logic       i_clk     = 1'b0;
    logic       i_rst_n   = 1'b0;
    logic       i_valid   = 1'b0;
    logic       o_ready;
    logic [7:0] i_in_byte = 8'h00;
    logic       o_valid;
    logic       i_ready   = 1'b0;
    logic [7:0] o_out_byte;
    logic       o_last;
    logic       o_stream_end;

    lzss_window_decompressor_core i_dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // decoder mirror
    lzwd_pkg::t_phase  dec_phase = lzwd_pkg::PH_FLAG;
    logic [7:0]        dec_flags = '0;
    logic [2:0]        dec_tok   = '0;
    logic [7:0]        dec_head  = '0;
    logic [7:0]        dec_win [lzwd_pkg::WIN_DEPTH];
    t_win_addr         dec_wp    = lzwd_pkg::WP_RESET;
    t_out_beat         plain_q [$];

    logic        row_typed = 1'b0;
    t_out_beat   row_beat  = '0;
    int unsigned fail_cnt  = 0;
    int unsigned sent_cnt  = 0;
    int unsigned cyc_cnt   = 0;
    int          tx_idle_pct  = 0;
    int          rx_stall_pct = 0;
    int unsigned rx_hold_req  = 0;
    int unsigned hold_left    = 0;

    task automatic win_put(input logic [7:0] c);
        dec_win[dec_wp] = c;
        dec_wp = dec_wp + 1'b1;
    endtask

    task automatic next_token();
        if (dec_tok == 3'd7) begin
            dec_tok   = '0;
            dec_phase = lzwd_pkg::PH_FLAG;
        end else begin
            dec_tok   = dec_tok + 1'b1;
            dec_phase = dec_flags[dec_tok] ? lzwd_pkg::PH_LIT : lzwd_pkg::PH_HEAD;
        end
    endtask

    task automatic inflate_byte(input logic [7:0] b);
        t_win_addr  src;
        logic [4:0] len;
        t_out_beat  ob;
        case (dec_phase)
            lzwd_pkg::PH_FLAG: begin
                dec_flags = b;
                dec_tok   = '0;
                dec_phase = b[0] ? lzwd_pkg::PH_LIT : lzwd_pkg::PH_HEAD;
            end
            lzwd_pkg::PH_LIT: begin
                win_put(b);
                plain_q.push_back(t_out_beat'{b, 1'b1, 1'b0});
                next_token();
            end
            lzwd_pkg::PH_HEAD: begin
                dec_head  = b;
                dec_phase = lzwd_pkg::PH_TAIL;
            end
            default: begin
                src = {dec_head[3:0], b};
                len = {1'b0, dec_head[7:4]} + lzwd_pkg::LEN_BIAS;
                if (src == lzwd_pkg::POS_END) begin
                    plain_q.push_back(t_out_beat'{8'h00, 1'b1, 1'b1});
                    dec_phase = lzwd_pkg::PH_FLAG;
                    dec_flags = '0;
                    dec_tok   = '0;
                    dec_head  = '0;
                    dec_wp    = lzwd_pkg::WP_RESET;
                end else begin
                    // read before write, so a copy can replay bytes it has just written
                    for (int i = 0; i < int'(len); i++) begin
                        ob.data       = dec_win[src];
                        ob.last       = (i == int'(len) - 1);
                        ob.stream_end = 1'b0;
                        win_put(ob.data);
                        plain_q.push_back(ob);
                        src = src + 1'b1;
                    end
                    next_token();
                end
            end
        endcase
    endtask

    // scoreboard: output beats checked before the input beat of the same edge is decoded
    always @(posedge i_clk) begin
        t_out_beat want;
        int        n_before;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (plain_q.size() == 0) begin
                    $error("unexpected beat: out_byte %02h last %0b stream_end %0b",
                           o_out_byte, o_last, o_stream_end);
                    fail_cnt++;
                end else begin
                    want = plain_q.pop_front();
                    if (o_out_byte !== want.data) begin
                        $error("out_byte: expected %02h, got %02h", want.data, o_out_byte);
                        fail_cnt++;
                    end
                    if (o_last !== want.last) begin
                        $error("last: expected %0b, got %0b", want.last, o_last);
                        fail_cnt++;
                    end
                    if (o_stream_end !== want.stream_end) begin
                        $error("stream_end: expected %0b, got %0b",
                               want.stream_end, o_stream_end);
                        fail_cnt++;
                    end
                end
            end
            if (i_valid && o_ready) begin
                n_before = plain_q.size();
                inflate_byte(i_in_byte);
                if (row_typed) begin
                    // table row carries its own answer; the mirror still tracks state
                    while (plain_q.size() > n_before) begin
                        void'(plain_q.pop_back());
                    end
                    plain_q.push_back(row_beat);
                end
            end
        end
    end

    // sink: random stalls plus a single long hold-off when requested
    always @(negedge i_clk) begin
        if (rx_hold_req != 0) begin
            hold_left   = rx_hold_req;
            rx_hold_req = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cyc_cnt++;
        if (cyc_cnt == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // entered and left just after a falling edge; valid is left high on return
    task automatic send_byte(input logic [7:0] b, input logic typed = 1'b0,
                             input t_out_beat beat = '0);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_in_byte <= b;
        row_typed <= typed;
        row_beat  <= beat;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
        sent_cnt++;
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (plain_q.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // one flag byte and its eight tokens, cut short by an end marker or replaced by noise
    task automatic send_frame(input int match_pct, input int long_pct,
                              input int end_pct, input int noise_pct);
        logic [7:0] flag;
        logic [3:0] nib;
        t_win_addr  pos;
        if ($urandom_range(99) < noise_pct) begin
            // garbage until the parser is back at a flag byte
            do send_byte(8'($urandom)); while (dec_phase != lzwd_pkg::PH_FLAG);
            return;
        end
        for (int k = 0; k < 8; k++) begin
            flag[k] = ($urandom_range(99) >= match_pct);
        end
        send_byte(flag);
        for (int k = 0; k < 8; k++) begin
            if (flag[k]) begin
                send_byte(8'($urandom));
            end else if ($urandom_range(99) < end_pct) begin
                send_byte({4'($urandom), lzwd_pkg::POS_END[11:8]});
                send_byte(lzwd_pkg::POS_END[7:0]);
                return;
            end else begin
                nib = ($urandom_range(99) < long_pct) ? 4'hF : 4'($urandom_range(15));
                if ($urandom_range(2) == 0) begin
                    pos = dec_wp - t_win_addr'($urandom_range(1, 17));
                end else begin
                    pos = t_win_addr'($urandom_range(1, lzwd_pkg::WIN_DEPTH - 1));
                end
                if (pos == lzwd_pkg::POS_END) begin
                    pos = lzwd_pkg::WIN_LAST;
                end
                send_byte({nib, pos[11:8]});
                send_byte(pos[7:0]);
            end
        end
    endtask

    initial begin
        int unsigned phase_from;
        foreach (dec_win[a]) begin
            dec_win[a] = 8'h00;
        end
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIR_TAB[r]) begin
            send_byte(DIR_TAB[r].in_b, DIR_TAB[r].typed, DIR_TAB[r].beat);
        end
        wait_drained();

        for (int p = 0; p < 4; p++) begin
            tx_idle_pct  = TX_IDLE[p];
            rx_stall_pct = RX_STALL[p];
            phase_from   = sent_cnt;
            if (p == 2) begin
                rx_hold_req = HOLD_CYC;
            end
            while (sent_cnt - phase_from < PHASE_ITEMS) begin
                send_frame(50, 30, 4, 10);
            end
            wait_drained();
        end

        repeat (SETTLE_CYC) @(negedge i_clk);
        if (fail_cnt == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

`default_nettype wire
